@@ hdl/lcet_pkg.sv @@
package lcet_pkg;

  localparam int DVD_W     = 84;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [63:0] EPOCH_1970_100NS = 64'h019D_B1DE_D53E_8000;
  localparam logic [31:0] K_MS             = 32'd1000;
  localparam logic [31:0] K_US             = 32'd1000000;
  localparam logic [31:0] DIV_WALL         = 32'd10;
  localparam logic [31:0] DIV_ADJ          = 32'd1000;

  localparam logic [31:0] FREQ_RESET  = 32'd10000000;
  localparam logic [15:0] LIMIT_RESET = 16'd100;

  localparam logic [7:0] REG_COUNTER_FREQ  = 8'd0;
  localparam logic [7:0] REG_LEAP_LIMIT_MS = 8'd1;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef struct packed {
    logic [31:0] freq;
    logic [15:0] limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NT,
    ST_MAG,
    ST_MUL0,
    ST_MUL1,
    ST_DIV,
    ST_WAIT,
    ST_OFF,
    ST_STEP,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_WALL,
    PH_CHECK,
    PH_ADJ,
    PH_MS,
    PH_US
  } phase_t;

endpackage

@@ hdl/lcet_cfg.sv @@
module lcet_cfg
  import lcet_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  logic [31:0] counter_freq;
  logic [15:0] leap_limit_ms;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_freq  <= FREQ_RESET;
      leap_limit_ms <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COUNTER_FREQ:  counter_freq  <= cfg_data;
        REG_LEAP_LIMIT_MS: leap_limit_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // zero frequency behaves as one
  assign cfg.freq  = (counter_freq == 32'd0) ? 32'd1 : counter_freq;
  assign cfg.limit = leap_limit_ms;

endmodule

@@ hdl/lcet_div.sv @@
module lcet_div
  import lcet_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [31:0]      dvs;
  logic [DVD_W-1:0] qr;
  logic [32:0]      t1, t2, r1, r2;
  logic             ge1, ge2;

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem, qr[DVD_W-1]};
    ge1 = t1 >= {1'b0, dvs};
    r1  = ge1 ? (t1 - {1'b0, dvs}) : t1;
    t2  = {r1[31:0], qr[DVD_W-2]};
    ge2 = t2 >= {1'b0, dvs};
    r2  = ge2 ? (t2 - {1'b0, dvs}) : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      qr  <= {qr[DVD_W-3:0], ge1, ge2};
      rem <= r2[31:0];
    end
  end

  assign quotient = qr;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_fell_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("divider stopped without done");

endmodule

@@ hdl/leap_compensated_elapsed_timer.sv @@
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata 160b, tuser req_type
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata 128b, tuser leap_fixed
// cfg       | in        | cfg_valid/cfg_ready          | cfg_index 8b, cfg_data 32b
//
// One transaction at a time; s_axis_tready is high only while idle and out of reset.
// Each division runs 42 two-bit steps of the one shared divider; a read does
// three divisions, four with correction.
// Synchronous reset clears the timing origin and config to defaults.
// A stalled result holds on m_axis until taken.
module leap_compensated_elapsed_timer
  import lcet_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [62:0] counter_value, [94:63] tick_ms, [157:95] system_time_100ns
  input  logic [159:0] s_axis_tdata,
  // [0] req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] elapsed_ms, [63:32] elapsed_us, [127:64] wall_time_us
  output logic [127:0] m_axis_tdata,
  // [0] leap_fixed
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t   cfg;
  state_t state, state_next;
  phase_t phase;

  logic        req_q;
  logic [62:0] cv_q;
  logic [31:0] tick_q;
  logic [62:0] st_q;

  logic [63:0] nt;
  logic        neg;
  logic [63:0] m;
  logic [63:0] mul_lo, mul_hi;
  logic [31:0] off;
  logic        fixed;
  logic [63:0] adj;
  logic [64:0] step;

  logic [63:0] start_count;
  logic [31:0] start_tick;
  logic [63:0] last_elapsed;
  logic [63:0] origin_wall_us;

  logic [31:0] res_ms, res_us;
  logic        res_fixed;

  logic [63:0]      mul_x;
  logic [31:0]      mul_k, mul_src;
  logic [63:0]      mul_prod;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [31:0]      div_dvs;
  logic             div_start, div_done;
  logic [63:0]      wall_diff;
  logic [31:0]      q_sgn, off_mag, diff;
  logic [63:0]      adj_val, sel;
  logic             big_off, take_adj;

  lcet_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcet_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared operand selection
  always_comb begin
    mul_x = (phase == PH_ADJ) ? {32'd0, off_mag} : m;
    case (phase)
      PH_ADJ:  mul_k = cfg.freq;
      PH_US:   mul_k = K_US;
      default: mul_k = K_MS;
    endcase
    mul_src  = (state == ST_MUL1) ? mul_x[63:32] : mul_x[31:0];
    mul_prod = {32'd0, mul_src} * {32'd0, mul_k};

    wall_diff = {1'b0, st_q} - EPOCH_1970_100NS;
    case (phase)
      PH_WALL: begin
        div_dvd = {20'd0, wall_diff};
        div_dvs = DIV_WALL;
      end
      PH_ADJ: begin
        div_dvd = {mul_hi[51:0], 32'd0} + {20'd0, mul_lo};
        div_dvs = DIV_ADJ;
      end
      default: begin
        div_dvd = {mul_hi[51:0], 32'd0} + {20'd0, mul_lo};
        div_dvs = cfg.freq;
      end
    endcase

    q_sgn    = neg ? (32'd0 - div_q[31:0]) : div_q[31:0];
    diff     = q_sgn - (tick_q - start_tick);
    off_mag  = off[31] ? (32'd0 - off) : off;
    big_off  = off_mag > {16'd0, cfg.limit};
    adj_val  = off[31] ? (64'd0 - div_q[63:0]) : div_q[63:0];
    take_adj = $signed({adj[63], adj}) < $signed(step);
    sel      = take_adj ? adj : step[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = (s_axis_tuser == REQ_READ) ? ST_NT : ST_DIV;
      end
      ST_NT:   state_next = ST_MAG;
      ST_MAG:  state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_DIV;
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          unique case (phase)
            PH_WALL:  state_next = ST_OUT;
            PH_CHECK: state_next = ST_OFF;
            PH_ADJ:   state_next = ST_STEP;
            PH_MS:    state_next = ST_MUL0;
            PH_US:    state_next = ST_OUT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_OFF:   state_next = big_off ? ST_MUL0 : ST_MAG;
      ST_STEP:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_MAG;
      ST_OUT: begin
        if (m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WALL;
      fixed <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          fixed <= 1'b0;
          phase <= (s_axis_tuser == REQ_READ) ? PH_CHECK : PH_WALL;
        end
        ST_WAIT: begin
          if (div_done && phase == PH_MS) phase <= PH_US;
        end
        ST_OFF: begin
          if (big_off) begin
            phase <= PH_ADJ;
            fixed <= 1'b1;
          end else begin
            phase <= PH_MS;
          end
        end
        ST_APPLY: phase <= PH_MS;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_q  <= s_axis_tuser;
          cv_q   <= s_axis_tdata[62:0];
          tick_q <= s_axis_tdata[94:63];
          st_q   <= s_axis_tdata[157:95];
        end
      end
      ST_NT: nt <= {1'b0, cv_q} - start_count;
      ST_MAG: begin
        neg <= nt[63];
        m   <= nt[63] ? (64'd0 - nt) : nt;
      end
      ST_MUL0: mul_lo <= mul_prod;
      ST_MUL1: mul_hi <= mul_prod;
      ST_WAIT: begin
        if (div_done) begin
          unique case (phase)
            PH_WALL: begin
              res_ms    <= '0;
              res_us    <= '0;
              res_fixed <= 1'b0;
            end
            PH_CHECK: off <= diff;
            PH_ADJ:   adj <= adj_val;
            PH_MS:    res_ms <= q_sgn;
            PH_US: begin
              res_us    <= q_sgn;
              res_fixed <= fixed;
            end
            default: ;
          endcase
        end
      end
      ST_STEP:  step <= {nt[63], nt} - {last_elapsed[63], last_elapsed};
      ST_APPLY: nt <= nt - sel;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_count    <= '0;
      start_tick     <= '0;
      last_elapsed   <= '0;
      origin_wall_us <= '0;
    end else begin
      if (state == ST_WAIT && div_done && phase == PH_WALL) begin
        start_count    <= {1'b0, cv_q};
        start_tick     <= tick_q;
        last_elapsed   <= '0;
        origin_wall_us <= div_q[63:0];
      end
      if (state == ST_MAG && phase == PH_MS) last_elapsed <= nt;
      if (state == ST_APPLY) start_count <= start_count + sel;
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {origin_wall_us, res_us, res_ms};
  assign m_axis_tuser  = res_fixed;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
      s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && req_q == REQ_RESTART) |-> (m_axis_tdata[63:0] == 64'd0 && !m_axis_tuser))
    else $error("restart result not zero");
  a_result_after_div: assert property (@(posedge clk) disable iff (rst)
      $rose(m_axis_tvalid) |-> $past(div_done))
    else $error("result shown without a finished division");
  a_apply_fixed: assert property (@(posedge clk) disable iff (rst)
      (state == ST_APPLY) |-> fixed)
    else $error("origin shifted without a leap flag");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lcet_pkg::*;

  localparam logic [7:0]  REG_SPARE = 8'd2;
  localparam logic [7:0]  REG_TOP   = 8'hFF;
  localparam logic [62:0] MAX63     = {63{1'b1}};
  localparam logic [31:0] T0        = 32'hFFFF_FFF0;

  typedef struct packed {
    logic [31:0] ms;
    logic [31:0] us;
    logic        leap;
    logic [63:0] wall_us;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  logic [31:0] freq_q;
  logic [15:0] limit_q;
  logic [63:0] origin_count;
  logic [31:0] origin_tick;
  logic [63:0] last_span;
  logic [63:0] wall_origin_us;

  reply_t pending_replies[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int n_restarts = 0;
  int n_reads = 0;
  int n_leaps = 0;
  int n_cfg_writes = 0;
  int n_replies = 0;

  leap_compensated_elapsed_timer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] scaled_ratio32(logic [63:0] t, logic [31:0] k,
                                                 logic [31:0] d);
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] quo;
    neg = t[63];
    mag = neg ? 64'd0 - t : t;
    quo = ({64'd0, mag} * {96'd0, k}) / {96'd0, d};
    return neg ? 32'd0 - quo[31:0] : quo[31:0];
  endfunction

  function automatic reply_t compute_timer_reply(logic kind, logic [62:0] cnt,
                                                 logic [31:0] tick, logic [62:0] wall);
    reply_t             r;
    logic [31:0]        f;
    logic [31:0]        diff;
    logic [63:0]        span;
    logic [63:0]        adj;
    longint             off;
    longint             lim;
    longint             adj_counts;
    logic signed [65:0] step;
    f = (freq_q == 32'd0) ? 32'd1 : freq_q;
    lim = {48'd0, limit_q};
    r = '0;
    if (kind == REQ_RESTART) begin
      origin_count = {1'b0, cnt};
      origin_tick = tick;
      last_span = '0;
      wall_origin_us = ({1'b0, wall} - EPOCH_1970_100NS) / 64'd10;
    end else begin
      span = {1'b0, cnt} - origin_count;
      diff = scaled_ratio32(span, K_MS, f) - (tick - origin_tick);
      off = $signed(diff);
      if (off > lim || off < -lim) begin
        adj_counts = (off * longint'({32'd0, f})) / 1000;
        step = $signed({{2{span[63]}}, span}) - $signed({{2{last_span[63]}}, last_span});
        // never step back past the previous reading
        if ($signed({{2{adj_counts[63]}}, adj_counts}) < step) adj = adj_counts;
        else adj = span - last_span;
        origin_count = origin_count + adj;
        span = span - adj;
        r.leap = 1'b1;
      end
      last_span = span;
      r.ms = scaled_ratio32(span, K_MS, f);
      r.us = scaled_ratio32(span, K_US, f);
    end
    r.wall_us = wall_origin_us;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 50) $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[31:0] !== want.ms)
          report_mismatch("elapsed_ms", {32'd0, m_axis_tdata[31:0]}, {32'd0, want.ms});
        if (m_axis_tdata[63:32] !== want.us)
          report_mismatch("elapsed_us", {32'd0, m_axis_tdata[63:32]}, {32'd0, want.us});
        if (m_axis_tuser !== want.leap)
          report_mismatch("leap_fixed", {63'd0, m_axis_tuser}, {63'd0, want.leap});
        if (m_axis_tdata[127:64] !== want.wall_us)
          report_mismatch("wall_time_us", m_axis_tdata[127:64], want.wall_us);
      end
    end
  end

  task automatic send_req(logic kind, logic [62:0] cnt, logic [31:0] tick, logic [62:0] wall);
    reply_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, wall, tick, cnt};
    do @(posedge clk); while (!s_axis_tready);
    r = compute_timer_reply(kind, cnt, tick, wall);
    pending_replies.push_back(r);
    if (kind == REQ_RESTART) n_restarts++;
    else n_reads++;
    if (r.leap) n_leaps++;
  endtask

  task automatic hold_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_replies();
    hold_stream();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_COUNTER_FREQ:  freq_q = value;
      REG_LEAP_LIMIT_MS: limit_q = value[15:0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic send_noise();
    send_req(1'($urandom_range(1)), 63'({$urandom, $urandom}), $urandom,
             63'({$urandom, $urandom}));
  endtask

  task automatic run_session(int n_rd);
    logic [63:0]     base;
    logic [63:0]     now_cnt;
    logic [63:0]     f64;
    logic [31:0]     tick0;
    longint unsigned e;
    int              lim;
    int              drift;
    int              mode;
    f64 = (freq_q == 32'd0) ? 64'd1 : {32'd0, freq_q};
    lim = int'(limit_q);
    base = {$urandom_range(32'h3FFF_FFFF), $urandom};
    tick0 = $urandom;
    send_req(REQ_RESTART, base[62:0], tick0, 63'({$urandom, $urandom}));
    e = 0;
    now_cnt = base;
    repeat (n_rd) begin
      mode = $urandom_range(5);
      if (mode != 4) begin
        e += $urandom_range(3000);
        now_cnt = base + e * f64 / 1000;
      end
      case (mode)
        2: drift = int'($urandom_range(2 * lim)) - lim;
        3: drift = ($urandom_range(1) ? 1 : -1) * (lim + 1 + int'($urandom_range(2000)));
        4: drift = -(lim + 1 + int'($urandom_range(2000)));
        default: drift = 0;
      endcase
      if (mode == 5) send_noise();
      else send_req(REQ_READ, now_cnt[62:0], tick0 + e[31:0] + drift,
                    63'({$urandom, $urandom}));
    end
  endtask

  task automatic test_directed_cases();
    send_req(REQ_READ, 63'd0, 32'd0, 63'd0);
    send_req(REQ_READ, MAX63, 32'hFFFF_FFFF, MAX63);
    send_req(REQ_RESTART, 63'd0, 32'd0, EPOCH_1970_100NS[62:0]);
    send_req(REQ_RESTART, 63'd0, 32'd0, 63'd0);
    send_req(REQ_RESTART, 63'd5, 32'd7, MAX63);
    send_req(REQ_RESTART, MAX63, 32'hFFFF_FFFF, 63'd1);
    send_req(REQ_READ, 63'd0, 32'd0, 63'd0);
    send_req(REQ_RESTART, 63'd1000, T0, EPOCH_1970_100NS[62:0] + 63'd10);
    send_req(REQ_READ, 63'd501000, T0 + 32'd50, 63'd0);
    send_req(REQ_READ, 63'd1001000, T0 + 32'd200, 63'd0);
    send_req(REQ_READ, 63'd1501000, T0 + 32'd251, 63'd0);
    send_req(REQ_READ, 63'd1501000, T0 + 32'd101, 63'd0);
    send_req(REQ_READ, 63'd11501000, T0 + 32'd1000, 63'd0);
    send_req(REQ_READ, 63'd11501000, T0 + 32'd1000, 63'd0);
    send_req(REQ_READ, 63'h0000_4000_0000_0000, T0, 63'd0);
    send_req(REQ_READ, MAX63, 32'hFFFF_FFFF, MAX63);
    send_req(REQ_READ, 63'd0, 32'h8000_0000, 63'd0);
  endtask

  task automatic test_register_settings();
    logic [31:0] f;
    logic [31:0] lim;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin f = 32'd1;           lim = 32'd0;     end
        1: begin f = 32'd0;           lim = 32'd65535; end
        2: begin f = 32'hFFFF_FFFF;   lim = 32'd0;     end
        3: begin f = 32'd1000;        lim = 32'd65535; end
        4: begin f = FREQ_RESET;      lim = {16'd0, LIMIT_RESET}; end
        5: begin f = 32'd3_579_545;   lim = 32'd1;     end
        6: begin f = $urandom;        lim = $urandom_range(65535); end
        default: begin
          f = $urandom_range(100_000_000, 1000);
          lim = $urandom_range(500);
        end
      endcase
      if (s == 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 32;
      end
      write_reg(REG_COUNTER_FREQ, f);
      write_reg(REG_LEAP_LIMIT_MS, {16'($urandom_range(16'hFFFF)), lim[15:0]});
      run_session($urandom_range(24, 12));
      run_session($urandom_range(24, 12));
    end
  endtask

  task automatic test_unknown_register();
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_TOP, 32'd1);
    run_session(4);
  endtask

  task automatic test_random_mix();
    int first;
    bit paused;
    first = n_restarts + n_reads;
    paused = 1'b0;
    while (n_restarts + n_reads - first < 180) begin
      if (!paused && n_restarts + n_reads - first >= 90) begin
        drain_replies();
        write_reg(REG_LEAP_LIMIT_MS, $urandom_range(300));
        paused = 1'b1;
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(4, 1)) send_noise();
      else run_session($urandom_range(15, 3));
    end
  endtask

  initial begin
    freq_q = FREQ_RESET;
    limit_q = LIMIT_RESET;
    origin_count = '0;
    origin_tick = '0;
    last_span = '0;
    wall_origin_us = '0;
    send_idle_pct = 32;
    recv_idle_pct = 81;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_settings();
    test_unknown_register();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix();
    drain_replies();
    repeat (250) @(posedge clk);
    $display("Sent %0d restarts and %0d reads (%0d leap corrections) over %0d register writes",
             n_restarts, n_reads, n_leaps, n_cfg_writes);
    $display("Checked %0d replies, %0d field mismatches", n_replies, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ leap_compensated_elapsed_timer.f @@
hdl/lcet_pkg.sv
hdl/lcet_cfg.sv
hdl/lcet_div.sv
hdl/leap_compensated_elapsed_timer.sv
bench/tb_top.sv
